/* hdl/nibc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nibc_pkg;

    localparam int NIB_W  = 4;
    localparam int MEM_D  = 16;
    localparam int ADDR_W = $clog2(MEM_D);

    // program loaded into memory at reset
    localparam logic [NIB_W-1:0] BOOT_IMAGE [MEM_D] = '{
        4'd9, 4'd13, 4'd14, 4'd14, 4'd5, 4'd7, 4'd13, 4'd10,
        4'd0, 4'd0,  4'd2,  4'd0,  4'd0, 4'd4, 4'd15, 4'd0
    };

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_STEP    = 2'd1,
        REQ_RESTART = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_BEEP  = 2'd1,
        EV_PRINT = 2'd2,
        EV_HALT  = 2'd3
    } t_event;

    typedef enum logic [3:0] {
        OP_HALT    = 4'd0,
        OP_ADD     = 4'd1,
        OP_SUB     = 4'd2,
        OP_INC_A   = 4'd3,
        OP_INC_B   = 4'd4,
        OP_DEC_A   = 4'd5,
        OP_DEC_B   = 4'd6,
        OP_BEEP    = 4'd7,
        OP_PRINT   = 4'd8,
        OP_LOAD_A  = 4'd9,
        OP_LOAD_B  = 4'd10,
        OP_STORE_A = 4'd11,
        OP_STORE_B = 4'd12,
        OP_JMP     = 4'd13,
        OP_JZ      = 4'd14,
        OP_JNZ     = 4'd15
    } t_opcode;

    typedef struct packed {
        logic [NIB_W-1:0]  reg_a;
        logic [NIB_W-1:0]  reg_b;
        logic [ADDR_W-1:0] ip;
        logic              halted;
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [NIB_W-1:0]  data;
    } t_wr;

    typedef struct packed {
        t_event            event_res;
        logic [NIB_W-1:0]  print_value;
        logic [NIB_W-1:0]  instr;
        logic [NIB_W-1:0]  reg_a;
        logic [NIB_W-1:0]  reg_b;
        logic [ADDR_W-1:0] pc;
    } t_result;

endpackage

`default_nettype wire

/* hdl/nibble_cpu_step.sv */
// Nibble machine, one word in, one word out.
// Input channel (i_in_valid / o_in_stall) carries a request: write one memory
// nibble (i_addr, i_data), execute one instruction, or restart the registers.
// Output channel (o_out_valid / i_out_stall) returns one result word per
// request: event code, printed nibble, opcode executed, and r0, r1 and the
// instruction pointer as they stand after the request.
// An accepted word lands in the input register and executes when the output
// register is free or draining; its result is then registered and held on the
// output ports with o_out_valid high. Throughput: one word per cycle unless
// the receiver stalls; the 16-nibble memory is a flop file, so the opcode,
// operand and indirect reads all happen in the execute cycle.
// Reset (synchronous, active low): memory reloads the built-in program, r0,
// r1, the pointer and the halt flag clear, both registers empty.
// When the receiver stalls, the result holds on the output ports; one more
// word waits in the input register, then o_in_stall rises until the output
// drains.
`timescale 1ns / 1ps
`default_nettype none

module nibble_cpu_step
    import nibc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [NIB_W-1:0]  i_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_event_res,
    output logic [NIB_W-1:0]       o_print_value,
    output logic [NIB_W-1:0]       o_instr,
    output logic [NIB_W-1:0]       o_reg_a,
    output logic [NIB_W-1:0]       o_reg_b,
    output logic [ADDR_W-1:0]      o_pc
);

    logic              r_in_valid;
    logic [1:0]        r_in_req;
    logic [ADDR_W-1:0] r_in_addr;
    logic [NIB_W-1:0]  r_in_data;
    t_state            r_state;
    logic              r_out_valid;
    t_result           r_res;

    t_state            n_state;
    t_wr               exec_wr;
    t_wr               mem_wr;
    t_result           exec_res;
    logic [NIB_W-1:0]  rd_op;
    logic [NIB_W-1:0]  rd_opnd;
    logic [NIB_W-1:0]  rd_ind;
    logic              out_ready;
    logic              adv;
    logic              in_take;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    // commit memory writes only when the word moves to the output
    always_comb begin
        mem_wr    = exec_wr;
        mem_wr.en = exec_wr.en && adv;
    end

    nibc_regfile u_mem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (mem_wr),
        .i_fetch_addr (r_state.ip),
        .i_opnd_addr  (r_state.ip + ADDR_W'(1)),
        .i_ind_addr   (rd_opnd),
        .o_fetch      (rd_op),
        .o_opnd       (rd_opnd),
        .o_ind        (rd_ind)
    );

    nibc_exec u_exec (
        .i_req   (r_in_req),
        .i_addr  (r_in_addr),
        .i_data  (r_in_data),
        .i_state (r_state),
        .i_op    (rd_op),
        .i_opnd  (rd_opnd),
        .i_ind   (rd_ind),
        .o_state (n_state),
        .o_wr    (exec_wr),
        .o_res   (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req  <= i_req_type;
            r_in_addr <= i_addr;
            r_in_data <= i_data;
        end
        if (adv) begin
            r_res <= exec_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_res.event_res;
    assign o_print_value = r_res.print_value;
    assign o_instr       = r_res.instr;
    assign o_reg_a       = r_res.reg_a;
    assign o_reg_b       = r_res.reg_b;
    assign o_pc          = r_res.pc;

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_req == REQ_RESTART) |=>
            (r_state == '0 && r_res.event_res == EV_NONE))
        else $error("restart did not clear machine state");

    a_halted_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_req == REQ_STEP && r_state.halted) |=>
            (r_state == $past(r_state) && r_res.event_res == EV_HALT
             && r_res.instr == '0))
        else $error("step while halted changed state");

    a_result_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.reg_a == r_state.reg_a && r_res.reg_b == r_state.reg_b
                         && r_res.pc == r_state.ip))
        else $error("result word disagrees with machine state");

    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_state))
        else $error("machine state moved without an executed word");

endmodule

`default_nettype wire

/* hdl/nibc_regfile.sv */
`timescale 1ns / 1ps
`default_nettype none

module nibc_regfile
    import nibc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_wr               i_wr,
    input  wire logic [ADDR_W-1:0] i_fetch_addr,
    input  wire logic [ADDR_W-1:0] i_opnd_addr,
    input  wire logic [ADDR_W-1:0] i_ind_addr,
    output logic      [NIB_W-1:0]  o_fetch,
    output logic      [NIB_W-1:0]  o_opnd,
    output logic      [NIB_W-1:0]  o_ind
);

    logic [NIB_W-1:0] r_mem [MEM_D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_D; i++) begin
                r_mem[i] <= BOOT_IMAGE[i];
            end
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_fetch = r_mem[i_fetch_addr];
    assign o_opnd  = r_mem[i_opnd_addr];
    assign o_ind   = r_mem[i_ind_addr];

endmodule

`default_nettype wire

/* hdl/nibc_exec.sv */
`timescale 1ns / 1ps
`default_nettype none

module nibc_exec
    import nibc_pkg::*;
(
    input  wire logic [1:0]        i_req,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [NIB_W-1:0]  i_data,
    input  wire t_state            i_state,
    input  wire logic [NIB_W-1:0]  i_op,
    input  wire logic [NIB_W-1:0]  i_opnd,
    input  wire logic [NIB_W-1:0]  i_ind,
    output t_state                 o_state,
    output t_wr                    o_wr,
    output t_result                o_res
);

    logic [ADDR_W-1:0] ip_next1;
    logic [ADDR_W-1:0] ip_next2;
    t_event            ev;
    logic [NIB_W-1:0]  pv;
    logic [NIB_W-1:0]  instr;

    assign ip_next1 = i_state.ip + ADDR_W'(1);
    assign ip_next2 = i_state.ip + ADDR_W'(2);

    always_comb begin
        o_state = i_state;
        o_wr    = '0;
        ev      = EV_NONE;
        pv      = '0;
        instr   = '0;
        unique case (t_req'(i_req))
            REQ_WRITE: begin
                o_wr.en   = 1'b1;
                o_wr.addr = i_addr;
                o_wr.data = i_data;
            end
            REQ_RESTART: begin
                o_state = '0;
            end
            REQ_STEP: begin
                if (i_state.halted) begin
                    ev = EV_HALT;
                end else begin
                    instr      = i_op;
                    o_state.ip = ip_next2;
                    unique case (t_opcode'(i_op))
                        OP_HALT: begin
                            ev             = EV_HALT;
                            o_state.halted = 1'b1;
                            o_state.ip     = i_state.ip;
                        end
                        OP_ADD: begin
                            o_state.reg_a = i_state.reg_a + i_state.reg_b;
                            o_state.ip    = ip_next1;
                        end
                        OP_SUB: begin
                            o_state.reg_a = i_state.reg_a - i_state.reg_b;
                            o_state.ip    = ip_next1;
                        end
                        OP_INC_A: begin
                            o_state.reg_a = i_state.reg_a + NIB_W'(1);
                            o_state.ip    = ip_next1;
                        end
                        OP_INC_B: begin
                            o_state.reg_b = i_state.reg_b + NIB_W'(1);
                            o_state.ip    = ip_next1;
                        end
                        OP_DEC_A: begin
                            o_state.reg_a = i_state.reg_a - NIB_W'(1);
                            o_state.ip    = ip_next1;
                        end
                        OP_DEC_B: begin
                            o_state.reg_b = i_state.reg_b - NIB_W'(1);
                            o_state.ip    = ip_next1;
                        end
                        OP_BEEP: begin
                            ev         = EV_BEEP;
                            o_state.ip = ip_next1;
                        end
                        OP_PRINT: begin
                            ev = EV_PRINT;
                            pv = i_opnd;
                        end
                        OP_LOAD_A: o_state.reg_a = i_ind;
                        OP_LOAD_B: o_state.reg_b = i_ind;
                        OP_STORE_A: begin
                            o_wr.en   = 1'b1;
                            o_wr.addr = i_opnd;
                            o_wr.data = i_state.reg_a;
                        end
                        OP_STORE_B: begin
                            o_wr.en   = 1'b1;
                            o_wr.addr = i_opnd;
                            o_wr.data = i_state.reg_b;
                        end
                        OP_JMP: o_state.ip = i_ind;
                        OP_JZ: begin
                            if (i_state.reg_a == '0) o_state.ip = i_ind;
                        end
                        OP_JNZ: begin
                            if (i_state.reg_a != '0) o_state.ip = i_ind;
                        end
                    endcase
                end
            end
            default: begin
                // unused request code: no change
            end
        endcase
    end

    always_comb begin
        o_res.event_res   = ev;
        o_res.print_value = pv;
        o_res.instr       = instr;
        o_res.reg_a       = o_state.reg_a;
        o_res.reg_b       = o_state.reg_b;
        o_res.pc          = o_state.ip;
    end

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import nibc_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_PCT     = 35;
    localparam int RANDOM_WORDS = 1600;
    localparam int CYCLE_LIMIT  = 200000;

    // program laid over the boot image for the directed run
    localparam int PROG_LEN = 13;
    localparam logic [ADDR_W-1:0] PROG_AT [PROG_LEN] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd11, 4'd13, 4'd14, 4'd15
    };
    localparam logic [NIB_W-1:0] PROG_NIB [PROG_LEN] = '{
        OP_INC_B, OP_INC_A, OP_ADD, OP_SUB, OP_DEC_B, OP_STORE_A, 4'd12,
        OP_STORE_B, OP_LOAD_B, OP_PRINT, OP_JNZ, 4'd13, OP_PRINT
    };

    typedef struct packed {
        logic              hold;
        logic [1:0]        req;
        logic [ADDR_W-1:0] addr;
        logic [NIB_W-1:0]  data;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    t_word shown = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [1:0]        o_event_res;
    logic [NIB_W-1:0]  o_print_value;
    logic [NIB_W-1:0]  o_instr;
    logic [NIB_W-1:0]  o_reg_a;
    logic [NIB_W-1:0]  o_reg_b;
    logic [ADDR_W-1:0] o_pc;

    t_word   request_q [$];
    t_result pending_results [$];

    // machine state as the predictor sees it
    logic [NIB_W-1:0]  shadow_mem [MEM_D];
    logic [NIB_W-1:0]  shadow_r0 = '0;
    logic [NIB_W-1:0]  shadow_r1 = '0;
    logic [ADDR_W-1:0] shadow_ip = '0;
    logic              shadow_halted = 1'b0;

    int  words_sent = 0;
    int  words_seen = 0;
    int  words_total = 0;
    int  useful_words = 0;
    int  mismatches = 0;
    int  cycles = 0;
    logic hold_next = 1'b0;
    logic calm;

    // no idling on either side for a stretch in the middle of the run
    assign calm = words_sent >= 700 && words_sent < 1000;

    nibble_cpu_step uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (shown.req),
        .i_addr        (shown.addr),
        .i_data        (shown.data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_event_res   (o_event_res),
        .o_print_value (o_print_value),
        .o_instr       (o_instr),
        .o_reg_a       (o_reg_a),
        .o_reg_b       (o_reg_b),
        .o_pc          (o_pc)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result execute_request(t_word w);
        t_result r;
        t_opcode op;
        logic [ADDR_W-1:0] opnd_at;
        logic [NIB_W-1:0] opnd, ind, a, b;
        logic [ADDR_W-1:0] nip;
        r = '0;
        r.event_res = EV_NONE;
        case (w.req)
            REQ_WRITE: begin
                shadow_mem[w.addr] = w.data;
            end
            REQ_RESTART: begin
                shadow_r0 = '0;
                shadow_r1 = '0;
                shadow_ip = '0;
                shadow_halted = 1'b0;
            end
            REQ_STEP: begin
                if (shadow_halted) begin
                    r.event_res = EV_HALT;
                end else begin
                    // operand fetch wraps from the last address to the first
                    opnd_at = shadow_ip + 4'd1;
                    opnd = shadow_mem[opnd_at];
                    ind = shadow_mem[opnd];
                    op = t_opcode'(shadow_mem[shadow_ip]);
                    a = shadow_r0;
                    b = shadow_r1;
                    nip = shadow_ip + 4'd2;
                    case (op)
                        OP_HALT: begin
                            r.event_res = EV_HALT;
                            shadow_halted = 1'b1;
                            nip = shadow_ip;
                        end
                        OP_ADD:    begin a = a + b;    nip = shadow_ip + 4'd1; end
                        OP_SUB:    begin a = a - b;    nip = shadow_ip + 4'd1; end
                        OP_INC_A:  begin a = a + 4'd1; nip = shadow_ip + 4'd1; end
                        OP_INC_B:  begin b = b + 4'd1; nip = shadow_ip + 4'd1; end
                        OP_DEC_A:  begin a = a - 4'd1; nip = shadow_ip + 4'd1; end
                        OP_DEC_B:  begin b = b - 4'd1; nip = shadow_ip + 4'd1; end
                        OP_BEEP: begin
                            r.event_res = EV_BEEP;
                            nip = shadow_ip + 4'd1;
                        end
                        OP_PRINT: begin
                            r.event_res = EV_PRINT;
                            r.print_value = opnd;
                        end
                        OP_LOAD_A:  a = ind;
                        OP_LOAD_B:  b = ind;
                        OP_STORE_A: shadow_mem[opnd] = a;
                        OP_STORE_B: shadow_mem[opnd] = b;
                        OP_JMP:     nip = ind;
                        OP_JZ:      if (a == 4'd0) nip = ind;
                        OP_JNZ:     if (a != 4'd0) nip = ind;
                    endcase
                    r.instr = op;
                    shadow_r0 = a;
                    shadow_r1 = b;
                    shadow_ip = nip;
                end
            end
            default: ;
        endcase
        r.reg_a = shadow_r0;
        r.reg_b = shadow_r1;
        r.pc = shadow_ip;
        return r;
    endfunction

    task automatic push_request(logic [1:0] req, logic [ADDR_W-1:0] addr,
                                logic [NIB_W-1:0] data);
        t_word w;
        w.hold = hold_next;
        w.req = req;
        w.addr = addr;
        w.data = data;
        hold_next = 1'b0;
        request_q.push_back(w);
        if (req != REQ_UNUSED)
            useful_words++;
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at word %0d: %s", words_seen, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // driver: present the next word when the channel is free
    always @(posedge i_clk) begin
        t_word next_w;
        logic send;
        logic accepted;
        if (i_rst_n) begin
            accepted = in_valid && !o_in_stall;
            if (accepted) begin
                pending_results.push_back(execute_request(shown));
                words_sent <= words_sent + 1;
            end
            if (!in_valid || !o_in_stall) begin
                send = request_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT);
                // hold the marked word until every result is back
                if (send && request_q[0].hold && (accepted || words_seen != words_sent))
                    send = 1'b0;
                if (send) begin
                    next_w = request_q.pop_front();
                    shown <= next_w;
                end
                in_valid <= send;
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with nothing pending");
                end else begin
                    want = pending_results.pop_front();
                    check_field("event_res", o_event_res, want.event_res);
                    check_field("print_value", o_print_value, want.print_value);
                    check_field("instr", o_instr, want.instr);
                    check_field("reg_a", o_reg_a, want.reg_a);
                    check_field("reg_b", o_reg_b, want.reg_b);
                    check_field("pc", o_pc, want.pc);
                end
                words_seen <= words_seen + 1;
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int n;
        logic mid_hold_done;
        mid_hold_done = 1'b0;
        shadow_mem = BOOT_IMAGE;

        // unused request type with every address and data bit set
        push_request(REQ_UNUSED, 4'd15, 4'd15);
        // boot program with a count of one: load, both jz outcomes, dec, beep,
        // jmp, halt, then a step while halted
        push_request(REQ_WRITE, 4'd13, 4'd1);
        repeat (8) push_request(REQ_STEP, 4'd0, 4'd0);
        // overwrite while halted, restart, run the remaining opcodes; the
        // last print sits at address 15 and fetches its operand from 0
        for (int k = 0; k < PROG_LEN; k++)
            push_request(REQ_WRITE, PROG_AT[k], PROG_NIB[k]);
        push_request(REQ_RESTART, 4'd0, 4'd0);
        repeat (11) push_request(REQ_STEP, 4'd0, 4'd0);
        // store b left a halt at address 0
        push_request(REQ_RESTART, 4'd0, 4'd0);
        push_request(REQ_STEP, 4'd0, 4'd0);

        useful_words = 0;
        hold_next = 1'b1;
        while (useful_words < RANDOM_WORDS) begin
            if (!mid_hold_done && useful_words >= 1200) begin
                hold_next = 1'b1;
                mid_hold_done = 1'b1;
            end
            if ($urandom_range(99) < 75) begin
                // patch a few nibbles, usually restart, then run a while
                n = $urandom_range(0, 5);
                repeat (n) push_request(REQ_WRITE, 4'($urandom_range(15)),
                                        4'($urandom_range(15)));
                if ($urandom_range(99) < 60)
                    push_request(REQ_RESTART, 4'($urandom_range(15)),
                                 4'($urandom_range(15)));
                n = $urandom_range(1, 20);
                repeat (n) push_request(REQ_STEP, 4'($urandom_range(15)),
                                        4'($urandom_range(15)));
            end else begin
                push_request(2'($urandom_range(3)), 4'($urandom_range(15)),
                             4'($urandom_range(15)));
            end
        end
        words_total = request_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_sent != words_total)
            @(posedge i_clk);
        while (words_seen != words_sent)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
